// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define KMI_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define KMI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/kmi_pkg.sv
// ---------------------------------------------------------------------------
// kmi_pkg
// Types and constants shared by the keyboard matrix injector modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kmi_pkg;

	localparam int MIN_HOLD_TICKS = 3;
	localparam int QUEUE_DEPTH    = 2;

	// Request kinds as they arrive on the stream.
	localparam logic [2:0] MODE_KEY       = 3'd0;
	localparam logic [2:0] MODE_JOY_BYTE  = 3'd1;
	localparam logic [2:0] MODE_SCAN_TICK = 3'd2;
	localparam logic [2:0] MODE_QUERY     = 3'd3;
	localparam logic [2:0] MODE_JOY_READ  = 3'd4;

	// Configuration register indexes.
	localparam logic REG_RELEASE_DETECT = 1'b0;
	localparam logic REG_SWAP_PORTS     = 1'b1;

	// Joystick direction bit positions.
	localparam logic [2:0] JOY_UP    = 3'd0;
	localparam logic [2:0] JOY_DOWN  = 3'd1;
	localparam logic [2:0] JOY_LEFT  = 3'd2;
	localparam logic [2:0] JOY_RIGHT = 3'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_KEY,
		OP_JOY,
		OP_TICK,
		OP_QUERY,
		OP_JOY_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] code_a;
		logic [7:0] code_b;
		logic [2:0] mods;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// File: sv/kmi_front.sv
// ---------------------------------------------------------------------------
// kmi_front
// Accepts stream requests, decodes the mode into a command and queues it.
// ---------------------------------------------------------------------------
`default_nettype none

module kmi_front import kmi_pkg::*; (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // first_code[7:0], second_code[15:8], modifier_bits[18:16]
	input  wire logic [2:0]  s_tuser,   // mode[2:0]
	input  wire q_status_t   q_stat,
	output logic             push,
	output cmd_t             cmd
);

	op_t op;

	always_comb begin
		case (s_tuser)
			MODE_KEY:       op = OP_KEY;
			MODE_JOY_BYTE:  op = OP_JOY;
			MODE_SCAN_TICK: op = OP_TICK;
			MODE_QUERY:     op = OP_QUERY;
			MODE_JOY_READ:  op = OP_JOY_READ;
			default:        op = OP_NONE;
		endcase
	end

	assign s_tready = !q_stat.full;

	// Unused modes are taken and dropped here; they never reach the queue.
	assign push = s_tvalid && s_tready && (op != OP_NONE);

	always_comb begin
		cmd.op     = op;
		cmd.code_a = s_tdata[7:0];
		cmd.code_b = s_tdata[15:8];
		cmd.mods   = s_tdata[18:16];
	end

endmodule

`default_nettype wire

// File: sv/kmi_fifo.sv
// ---------------------------------------------------------------------------
// kmi_fifo
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module kmi_fifo import kmi_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cmd_t      push_cmd,
	input  wire logic      pop,
	output cmd_t           head,
	output q_status_t      q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == FULL_COUNT);
	assign q_stat.empty = (count_q == '0);

endmodule

`default_nettype wire

// File: sv/kmi_back.sv
// ---------------------------------------------------------------------------
// kmi_back
// Executes queued commands on the key, matrix and joystick state and
// registers the read results.
// ---------------------------------------------------------------------------
`default_nettype none

module kmi_back import kmi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic       cfg_data,
	input  wire q_status_t  q_stat,
	input  wire cmd_t       head,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata    // read_data[7:0]
);

	localparam logic [7:0] COL_SHIFT = 8'hfd;
	localparam logic [7:0] COL_RSHIFT = 8'hbf;
	localparam logic [7:0] COL_CTRL = 8'h7f;
	localparam logic [7:0] ALL_ONES = 8'hff;
	localparam logic [7:0] RELEASE_BYTE = 8'hff;
	localparam logic [1:0] HOLD_MIN = 2'(MIN_HOLD_TICKS);
	localparam logic [1:0] HOLD_SAT = 2'd3;

	logic       release_detect_q;
	logic       swap_ports_q;
	logic [7:0] key_column_q;
	logic [7:0] key_row_q;
	logic [2:0] modifiers_q;
	logic       key_held_q;
	logic [1:0] hold_count_q;
	logic [7:0] shown_column_q;
	logic [7:0] shown_row_q;
	logic [7:0] joystick_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;

	logic       produces;
	logic       exec;
	logic       show_key;
	logic [7:0] c1;
	logic [7:0] c2;
	logic [7:0] query_rows;
	logic [7:0] joy_next;

	// Row bits seen for a column select, with the modifier keys faked in.
	function automatic logic [7:0] matrix_rows(input logic [7:0] sel, input logic [7:0] col,
			input logic [7:0] row, input logic [2:0] mods);
		logic [7:0] r;
		if (sel == 8'h00) begin
			r = row;
		end else if (mods[0] && mods[2]) begin
			r = (sel == col) ? row : ALL_ONES;
		end else if (!sel[1] && mods[0]) begin
			r = (col == COL_SHIFT) ? (row & 8'h7f) : 8'h7f;
		end else if (!sel[6] && mods[0]) begin
			r = (col == COL_RSHIFT) ? (row & 8'hef) : 8'hef;
		end else if (!sel[7] && mods[1]) begin
			r = (col == COL_CTRL) ? (row & 8'hfb) : 8'hfb;
		end else if (!sel[7] && mods[2]) begin
			r = (col == COL_CTRL) ? (row & 8'hdf) : 8'hdf;
		end else begin
			r = (sel == col) ? row : ALL_ONES;
		end
		return r;
	endfunction

	assign produces = (head.op == OP_QUERY) || (head.op == OP_JOY_READ);
	assign pop      = !q_stat.empty && (!produces || !out_valid_q || m_tready);
	assign exec     = pop;

	assign show_key = (release_detect_q && key_held_q) || (hold_count_q < HOLD_MIN);
	assign c1 = swap_ports_q ? shown_row_q : shown_column_q;
	assign c2 = swap_ports_q ? shown_column_q : shown_row_q;
	assign query_rows = matrix_rows(head.code_a, c1, c2, modifiers_q);

	// A press clears its bit and forces the opposite direction released.
	always_comb begin
		joy_next = joystick_q;
		if (head.code_a[6:3] == 4'd0) begin
			if (head.code_a[7]) begin
				joy_next[head.code_a[2:0]] = 1'b1;
			end else begin
				joy_next[head.code_a[2:0]] = 1'b0;
				case (head.code_a[2:0])
					JOY_LEFT:  joy_next[JOY_RIGHT] = 1'b1;
					JOY_RIGHT: joy_next[JOY_LEFT] = 1'b1;
					JOY_UP:    joy_next[JOY_DOWN] = 1'b1;
					JOY_DOWN:  joy_next[JOY_UP] = 1'b1;
					default:   ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_detect_q <= 1'b1;
			swap_ports_q     <= 1'b0;
			modifiers_q      <= '0;
			key_held_q       <= 1'b0;
			hold_count_q     <= HOLD_SAT;
			shown_column_q   <= ALL_ONES;
			shown_row_q      <= ALL_ONES;
			joystick_q       <= ALL_ONES;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RELEASE_DETECT: release_detect_q <= cfg_data;
					REG_SWAP_PORTS:     swap_ports_q <= cfg_data;
					default:            ;
				endcase
			end
			if (exec) begin
				case (head.op)
					OP_KEY: begin
						modifiers_q  <= head.mods;
						hold_count_q <= '0;
						key_held_q   <= 1'b1;
					end
					OP_JOY: begin
						if (head.code_a == RELEASE_BYTE) begin
							key_held_q <= 1'b0;
						end
						joystick_q <= joy_next;
					end
					OP_TICK: begin
						if (show_key) begin
							shown_column_q <= key_column_q;
							shown_row_q    <= key_row_q;
							if (hold_count_q != HOLD_SAT) begin
								hold_count_q <= hold_count_q + 1'b1;
							end
						end else begin
							shown_column_q <= ALL_ONES;
							shown_row_q    <= ALL_ONES;
						end
					end
					default: ;
				endcase
			end
			if (exec && produces) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec && (head.op == OP_KEY)) begin
			key_column_q <= head.code_a;
			key_row_q    <= head.code_b;
		end
		if (exec && produces) begin
			out_data_q <= (head.op == OP_QUERY) ? query_rows : joystick_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: sv/keyboard_matrix_injector_unit.sv
// A request is accepted when the command queue has room; a query or joystick read
// shows its result on m_tvalid after the queue entry and the output register, other
// requests give none. Throughput is one request per cycle while m_tready takes read
// results, set by the execute stage in the back end fed from a two-entry command queue.
// arst_n clears the queue and output valid and restores register and key/joystick
// reset values; no clearing pass is needed.
// ---------------------------------------------------------------------------
// keyboard_matrix_injector_unit
// Keyboard matrix and joystick port emulation fed by remote key events.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module keyboard_matrix_injector_unit import kmi_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // first_code[7:0], second_code[15:8], modifier_bits[18:16]
	input  wire logic [2:0]  s_tuser,   // mode[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // read_data[7:0]
);

	q_status_t q_stat;
	cmd_t      push_cmd;
	cmd_t      head;
	logic      push;
	logic      pop;
	logic      read_pop;

	kmi_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (push_cmd)
	);

	kmi_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	kmi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	assign read_pop = pop && ((head.op == OP_QUERY) || (head.op == OP_JOY_READ));

	`KMI_ASSERT_IMPLY(a_pop_nonempty, pop, !q_stat.empty, "pop from an empty command queue")
	`KMI_ASSERT_NEXT(a_push_kept, push && !pop, !q_stat.empty, "queued command was lost")
	`KMI_ASSERT_NEXT(a_read_result, read_pop, m_tvalid, "read executed without a result")

endmodule

`default_nettype wire

// File: dv/tb_keyboard_matrix_injector_unit.sv
// ---------------------------------------------------------------------------
// tb_keyboard_matrix_injector_unit
// Self-checking bench for the keyboard matrix injector. A queue-fed driver
// sends key events, joystick bytes, scan ticks, queries, joystick reads and
// spare modes. A monitor keeps its own copy of the key, hold and joystick
// state, works out the read data of every accepted query or joystick read and compares it with the returned data.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_keyboard_matrix_injector_unit;
	import kmi_pkg::*;

	// Request kinds that the block accepts but ignores.
	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	// Matrix positions of the faked modifier keys and the row bits they pull low.
	localparam logic [7:0] COL_LSHIFT   = 8'hfd;
	localparam logic [7:0] COL_RSHIFT   = 8'hbf;
	localparam logic [7:0] COL_CTRL_CBM = 8'h7f;
	localparam logic [7:0] ROW_LSHIFT   = 8'h7f;
	localparam logic [7:0] ROW_RSHIFT   = 8'hef;
	localparam logic [7:0] ROW_CTRL     = 8'hfb;
	localparam logic [7:0] ROW_CBM      = 8'hdf;
	localparam logic [7:0] ALL_OPEN     = 8'hff;
	localparam logic [7:0] RELEASE_BYTE = 8'hff;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] col_code;
		logic [7:0] row_code;
		logic [2:0] mods;
	} kb_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // first_code[7:0], second_code[15:8], modifier_bits[18:16]
	logic [2:0]  s_tuser = '0;   // mode[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // read_data[7:0]

	keyboard_matrix_injector_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	kb_req_t    pend_q[$];
	logic [7:0] read_data_q[$];
	kb_req_t    drv_req;
	int         stall_pct = 33;
	int         errors = 0;

	// Mirror of the block state.
	logic       cfg_release = 1'b1;
	logic       cfg_swap = 1'b0;
	logic [7:0] key_col = '0;
	logic [7:0] key_row = '0;
	logic [2:0] key_mods = '0;
	logic       held = 1'b0;
	logic [1:0] hold_cnt = 2'd3;
	logic [7:0] show_col = 8'hff;
	logic [7:0] show_row = 8'hff;
	logic [7:0] joy_bits = 8'hff;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	function automatic logic [7:0] matrix_rows(input logic [7:0] sel);
		logic [7:0] c1;
		logic [7:0] c2;
		c1 = cfg_swap ? show_row : show_col;
		c2 = cfg_swap ? show_col : show_row;
		if (sel == 8'h00)
			return c2;
		// Shift together with commodore disables every faked key.
		if (key_mods[0] && key_mods[2])
			return (sel == c1) ? c2 : ALL_OPEN;
		if (!sel[1] && key_mods[0])
			return (c1 == COL_LSHIFT) ? (c2 & ROW_LSHIFT) : ROW_LSHIFT;
		if (!sel[6] && key_mods[0])
			return (c1 == COL_RSHIFT) ? (c2 & ROW_RSHIFT) : ROW_RSHIFT;
		if (!sel[7] && key_mods[1])
			return (c1 == COL_CTRL_CBM) ? (c2 & ROW_CTRL) : ROW_CTRL;
		if (!sel[7] && key_mods[2])
			return (c1 == COL_CTRL_CBM) ? (c2 & ROW_CBM) : ROW_CBM;
		return (sel == c1) ? c2 : ALL_OPEN;
	endfunction

	task automatic apply_request(input kb_req_t r, output bit has_data,
			output logic [7:0] rd);
		logic [6:0] dir;
		has_data = 1'b0;
		rd = '0;
		case (r.mode)
			MODE_KEY: begin
				key_col  = r.col_code;
				key_row  = r.row_code;
				key_mods = r.mods;
				hold_cnt = 2'd0;
				held     = 1'b1;
			end
			MODE_JOY_BYTE: begin
				dir = r.col_code[6:0];
				if (r.col_code == RELEASE_BYTE)
					held = 1'b0;
				if (dir < 7'd8) begin
					if (r.col_code[7]) begin
						joy_bits[dir[2:0]] = 1'b1;
					end else begin
						joy_bits[dir[2:0]] = 1'b0;
						case (dir[2:0])
							JOY_LEFT:  joy_bits[JOY_RIGHT] = 1'b1;
							JOY_RIGHT: joy_bits[JOY_LEFT]  = 1'b1;
							JOY_UP:    joy_bits[JOY_DOWN]  = 1'b1;
							JOY_DOWN:  joy_bits[JOY_UP]    = 1'b1;
							default: ;
						endcase
					end
				end
			end
			MODE_SCAN_TICK: begin
				if ((cfg_release && held) || hold_cnt < MIN_HOLD_TICKS) begin
					show_col = key_col;
					show_row = key_row;
					if (hold_cnt != 2'd3)
						hold_cnt++;
				end else begin
					show_col = ALL_OPEN;
					show_row = ALL_OPEN;
				end
			end
			MODE_QUERY: begin
				has_data = 1'b1;
				rd = matrix_rows(r.col_code);
			end
			MODE_JOY_READ: begin
				has_data = 1'b1;
				rd = joy_bits;
			end
			default: ;
		endcase
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= stall_pct) begin
				drv_req = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {5'b0, drv_req.mods, drv_req.row_code, drv_req.col_code};
				s_tuser  <= drv_req.mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker first, then the accepted request updates the mirror.
	always @(posedge clk) begin : monitor
		kb_req_t    acc;
		bit         has_data;
		logic [7:0] rd;
		logic [7:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (read_data_q.size() == 0) begin
					note_error($sformatf("unexpected read data %02h", m_tdata));
				end else begin
					want = read_data_q.pop_front();
					if (m_tdata !== want)
						note_error($sformatf("read_data mismatch: expected %02h, got %02h",
							want, m_tdata));
				end
			end
			if (s_tvalid && s_tready) begin
				acc.mode     = s_tuser;
				acc.col_code = s_tdata[7:0];
				acc.row_code = s_tdata[15:8];
				acc.mods     = s_tdata[18:16];
				apply_request(acc, has_data, rd);
				if (has_data)
					read_data_q.push_back(rd);
			end
		end
	end

	task automatic push_req(input logic [2:0] mode, input logic [7:0] a,
			input logic [7:0] b, input logic [2:0] m);
		kb_req_t r;
		r.mode = mode;
		r.col_code = a;
		r.row_code = b;
		r.mods = m;
		pend_q.push_back(r);
	endtask

	function automatic logic [7:0] pick_code();
		case ($urandom_range(7))
			0: return COL_LSHIFT;
			1: return COL_RSHIFT;
			2: return COL_CTRL_CBM;
			3: return ALL_OPEN;
			4: return 8'h00;
			5, 6: return ~(8'h01 << $urandom_range(7));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Waits until no request is pending and every read has come back, or gives up and reports what is still outstanding.
	task automatic drain();
		int waited;
		waited = 0;
		while ((pend_q.size() != 0 || s_tvalid || read_data_q.size() != 0)
				&& waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		if (read_data_q.size() != 0 || pend_q.size() != 0)
			note_error($sformatf("stuck with %0d reads outstanding, %0d requests pending",
				read_data_q.size(), pend_q.size()));
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RELEASE_DETECT: cfg_release = val;
			REG_SWAP_PORTS:     cfg_swap = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Mostly well-formed key and joystick sequences with random content.
	task automatic fill_random(input int count);
		int         made;
		logic [7:0] c;
		logic [7:0] r;
		logic [7:0] b;
		made = 0;
		while (made < count) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					c = pick_code();
					r = pick_code();
					push_req(MODE_KEY, c, r, 3'($urandom_range(7)));
					made++;
					repeat ($urandom_range(1, 5)) begin
						push_req(MODE_SCAN_TICK, 8'($urandom_range(255)),
							8'($urandom_range(255)), 3'($urandom_range(7)));
						made++;
						repeat ($urandom_range(0, 2)) begin
							case ($urandom_range(4))
								0: b = 8'h00;
								1: b = c;
								2: b = r;
								default: b = pick_code();
							endcase
							push_req(MODE_QUERY, b, 8'($urandom_range(255)), 3'($urandom_range(7)));
							made++;
						end
					end
					if ($urandom_range(1)) begin
						push_req(MODE_JOY_BYTE, RELEASE_BYTE, 8'h00, 3'd0);
						made++;
						repeat ($urandom_range(1, 3)) begin
							push_req(MODE_SCAN_TICK, 8'h00, 8'h00, 3'd0);
							push_req(MODE_QUERY, $urandom_range(1) ? c : r, 8'h00, 3'd0);
							made += 2;
						end
					end
				end
				6, 7: begin
					repeat ($urandom_range(2, 6)) begin
						case ($urandom_range(5))
							0, 1: b = {1'b0, 7'($urandom_range(3))};
							2:    b = {1'b1, 7'($urandom_range(3))};
							3:    b = {1'($urandom_range(1)), 7'($urandom_range(4, 7))};
							4:    b = {1'($urandom_range(1)), 7'($urandom_range(8, 127))};
							default: b = RELEASE_BYTE;
						endcase
						push_req(MODE_JOY_BYTE, b, 8'($urandom_range(255)), 3'($urandom_range(7)));
						made++;
						if ($urandom_range(1)) begin
							push_req(MODE_JOY_READ, 8'($urandom_range(255)),
								8'($urandom_range(255)), 3'($urandom_range(7)));
							made++;
						end
					end
				end
				default: begin
					b = 8'($urandom_range(7));
					push_req(b[2:0], 8'($urandom_range(255)), 8'($urandom_range(255)),
						3'($urandom_range(7)));
					if (b[2:0] <= MODE_JOY_READ)
						made++;
				end
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_RELEASE_DETECT, 1'b1);
		write_reg(REG_SWAP_PORTS, 1'b0);

		// Reset view before any key event: open matrix, idle joystick.
		push_req(MODE_QUERY, 8'h00, 8'h00, 3'd0);
		push_req(MODE_JOY_READ, 8'h00, 8'h00, 3'd0);
		push_req(MODE_SCAN_TICK, 8'h00, 8'h00, 3'd0);
		push_req(MODE_QUERY, 8'hfe, 8'h00, 3'd0);
		// Shift held on the left shift column.
		push_req(MODE_KEY, COL_LSHIFT, ROW_LSHIFT, 3'b001);
		push_req(MODE_SCAN_TICK, 8'h00, 8'h00, 3'd0);
		push_req(MODE_QUERY, COL_LSHIFT, 8'h00, 3'd0);
		push_req(MODE_QUERY, 8'hff, 8'hff, 3'd7);
		// Right shift, ctrl and commodore positions.
		push_req(MODE_KEY, COL_RSHIFT, 8'hfe, 3'b001);
		push_req(MODE_SCAN_TICK, 8'h00, 8'h00, 3'd0);
		push_req(MODE_QUERY, COL_RSHIFT, 8'h00, 3'd0);
		push_req(MODE_KEY, COL_CTRL_CBM, ROW_CTRL, 3'b010);
		push_req(MODE_SCAN_TICK, 8'h00, 8'h00, 3'd0);
		push_req(MODE_QUERY, COL_CTRL_CBM, 8'h00, 3'd0);
		push_req(MODE_KEY, COL_CTRL_CBM, 8'hff, 3'b100);
		push_req(MODE_SCAN_TICK, 8'h00, 8'h00, 3'd0);
		push_req(MODE_QUERY, COL_CTRL_CBM, 8'h00, 3'd0);
		// Shift plus commodore, then field extremes.
		push_req(MODE_KEY, 8'h00, 8'hff, 3'b111);
		push_req(MODE_SCAN_TICK, 8'hff, 8'hff, 3'd7);
		push_req(MODE_QUERY, 8'h00, 8'h00, 3'd0);
		// Joystick: press left then right, press up, read, out of range, release byte.
		push_req(MODE_JOY_BYTE, {5'b0, JOY_LEFT}, 8'h00, 3'd0);
		push_req(MODE_JOY_BYTE, {5'b0, JOY_RIGHT}, 8'h00, 3'd0);
		push_req(MODE_JOY_BYTE, {5'b0, JOY_UP}, 8'h00, 3'd0);
		push_req(MODE_JOY_READ, 8'h00, 8'h00, 3'd0);
		push_req(MODE_JOY_BYTE, 8'h08, 8'h00, 3'd0);
		push_req(MODE_JOY_BYTE, RELEASE_BYTE, 8'h00, 3'd0);
		// The minimum hold has not run out yet, so the tick still shows the key.
		push_req(MODE_SCAN_TICK, 8'h00, 8'h00, 3'd0);
		push_req(MODE_QUERY, 8'h00, 8'h00, 3'd0);
		push_req(MODE_SPARE_5, 8'hff, 8'hff, 3'd7);
		push_req(MODE_SPARE_6, 8'h00, 8'h00, 3'd0);
		push_req(MODE_SPARE_7, 8'h5a, 8'ha5, 3'd5);
		push_req(MODE_JOY_READ, 8'h00, 8'h00, 3'd0);
		drain();

		write_reg(REG_RELEASE_DETECT, 1'b0);
		write_reg(REG_SWAP_PORTS, 1'b0);
		fill_random(150);
		drain();

		// Both sides run without gaps in this phase.
		stall_pct = 0;
		write_reg(REG_RELEASE_DETECT, 1'b1);
		write_reg(REG_SWAP_PORTS, 1'b1);
		fill_random(150);
		drain();
		stall_pct = 33;

		write_reg(REG_RELEASE_DETECT, 1'b0);
		write_reg(REG_SWAP_PORTS, 1'b1);
		fill_random(150);
		drain();

		write_reg(REG_RELEASE_DETECT, 1'b1);
		write_reg(REG_SWAP_PORTS, 1'b0);
		fill_random(150);
		drain();

		write_reg(REG_SWAP_PORTS, 1'b1);
		fill_random(125);
		drain();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
